// ===== rtl/assert_macros.svh =====
// assertion macros for the beamformer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CWB_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CWB_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CWB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/cwb_pkg.sv =====
`default_nettype none
package cwb_pkg;
    localparam int unsigned SUM_W = 32;
    localparam int unsigned NIB_OFFSET = 8;
    localparam logic [0:0] FUNC_WEIGHT = 1'b0;
    localparam logic [0:0] FUNC_SAMPLE = 1'b1;
    localparam logic [0:0] REG_BEAM_COUNT = 1'b0;
    localparam logic [0:0] REG_POL_COUNT = 1'b1;
    localparam logic [4:0] BEAM_COUNT_RESET = 5'd10;
    localparam logic [1:0] POL_COUNT_RESET = 2'd2;

    typedef struct packed {
        logic [3:0] beam_index;
        logic       pol_index;
        logic signed [31:0] sum_real;
        logic signed [31:0] sum_imag;
        logic       last_of_sample;
    } result_t;

    typedef struct packed {
        logic       func;
        logic [3:0] weight_beam;
        logic       weight_pol;
        logic [9:0] weight_element;
        logic signed [15:0] weight_real;
        logic signed [15:0] weight_imag;
        logic [7:0] sample_byte;
    } item_t;

    // control shared by every cell of the row
    typedef struct packed {
        logic       mac;
        logic       clr;
        logic       shift;
        logic       pol;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0] cfg_index;
        logic [4:0] cfg_data;
    } cfg_t;
endpackage
`default_nettype wire

// ===== rtl/cwb_if.sv =====
`default_nettype none
interface cwb_item_if import cwb_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cwb_result_if import cwb_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cwb_cfg_if import cwb_pkg::*; ();
    logic valid;
    logic ready;
    cfg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/cwb_cell.sv =====
`default_nettype none
// one beam accumulator pair: adds its product, shifts toward the output end
module cwb_cell import cwb_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctl_t         ctl,
    input  wire logic              sel,
    input  wire logic signed [31:0] prod_re,
    input  wire logic signed [31:0] prod_im,
    input  wire logic signed [63:0] nbr_in,
    output logic signed [63:0]      acc_out
);
    logic signed [31:0] p0_re_reg, p0_im_reg, p1_re_reg, p1_im_reg;
    logic signed [31:0] p0_re_next, p0_im_next, p1_re_next, p1_im_next;

    // clear all sums, else shift pol-fastest, else accumulate into the addressed polarisation
    always_comb
    begin
        p0_re_next = p0_re_reg;
        p0_im_next = p0_im_reg;
        p1_re_next = p1_re_reg;
        p1_im_next = p1_im_reg;
        if (ctl.clr)
        begin
            p0_re_next = '0;
            p0_im_next = '0;
            p1_re_next = '0;
            p1_im_next = '0;
        end
        else if (ctl.shift)
        begin
            p0_re_next = p1_re_reg;
            p0_im_next = p1_im_reg;
            p1_re_next = nbr_in[63:32];
            p1_im_next = nbr_in[31:0];
        end
        else if (ctl.mac && sel)
        begin
            if (ctl.pol)
            begin
                p1_re_next = p1_re_reg + prod_re;
                p1_im_next = p1_im_reg + prod_im;
            end
            else
            begin
                p0_re_next = p0_re_reg + prod_re;
                p0_im_next = p0_im_reg + prod_im;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_re_reg <= '0;
            p0_im_reg <= '0;
            p1_re_reg <= '0;
            p1_im_reg <= '0;
        end
        else
        begin
            p0_re_reg <= p0_re_next;
            p0_im_reg <= p0_im_next;
            p1_re_reg <= p1_re_next;
            p1_im_reg <= p1_im_next;
        end
    end

    assign acc_out = {p0_re_reg, p0_im_reg};
endmodule
`default_nettype wire

// ===== rtl/complex_weighted_beamformer_core.sv =====
`default_nettype none
// Complex weighted beamformer. A weight transaction (func 0) stores one
// complex weight in the weight memory and leaves the core idle. A sample
// transaction (func 1) reads the weight of every active beam from that
// memory, one beam per cycle, through one shared complex multiplier, and
// the input is not ready again until the product of every active beam has
// been added to its sum. The per-beam sums sit in a row of accumulator
// cells. After the last element of a time sample the row shifts out two
// slots per beam, beam-major with polarisation fastest, one slot per cycle
// while the output is taken. With two polarisations that is one result per
// cycle. With one polarisation the unused slot is also shifted out, but
// without a result. An output register lets the next input wait only on the
// row. Register writes are taken only while the core is idle, and a write to
// either register clears the sums and the element position.
module complex_weighted_beamformer_core import cwb_pkg::*; #(
    parameter int MAX_BEAMS = 16,
    parameter int ELEMENTS_PER_POL = 1024,
    parameter int WEIGHT_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cwb_item_if.sink     in_ch,
    cwb_result_if.source out_ch,
    cwb_cfg_if.sink      cfg_ch
);
    localparam int BW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int EW = $clog2(ELEMENTS_PER_POL);
    localparam int AW = BW + 1 + EW;
    localparam int CW = $clog2(MAX_BEAMS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_OUT  = 3'd2;

    logic [2:0] state_reg, state_next;
    logic [4:0] beam_count_reg;
    logic [1:0] pol_count_reg;
    logic [EW:0] pos_reg, pos_next;
    logic [CW-1:0] nb;
    logic [1:0] np;
    logic [CW:0] cnt_reg, cnt_next;
    logic [3:0] sre_reg, sim_reg;
    logic cur_pol_reg, last_pos_reg;

    // saturate the registers
    always_comb
    begin
        if (beam_count_reg == 5'd0)
            nb = CW'(1);
        else if (32'(beam_count_reg) > MAX_BEAMS)
            nb = CW'(MAX_BEAMS);
        else
            nb = CW'(beam_count_reg);
        np = (pol_count_reg == 2'd0) ? 2'd1 : ((pol_count_reg > 2'd2) ? 2'd2 : pol_count_reg);
    end

    // weight memory
    logic [2*WEIGHT_WIDTH-1:0] wmem [0:(1<<AW)-1];
    logic [2*WEIGHT_WIDTH-1:0] wrd_reg;
    logic [AW-1:0] raddr;
    logic rd_en, wr_en;
    item_t it;
    assign it = in_ch.payload;
    assign wr_en = in_ch.valid && in_ch.ready && it.func == FUNC_WEIGHT
        && 32'(it.weight_beam) < MAX_BEAMS && 32'(it.weight_element) < ELEMENTS_PER_POL;

    // weights are sign-extended or truncated to the stored width
    always_ff @(posedge clk)
    begin
        if (wr_en)
            wmem[{BW'(it.weight_beam), it.weight_pol, EW'(it.weight_element)}] <=
                {WEIGHT_WIDTH'(it.weight_real), WEIGHT_WIDTH'(it.weight_imag)};
        if (rd_en)
            wrd_reg <= wmem[raddr];
    end

    // read pipeline: weight read at cnt into wrd_reg, then the registered product, then the add
    logic rd_v_reg, mul_v_reg;
    logic [CW-1:0] rd_b_reg, mul_b_reg;
    logic signed [31:0] prod_re_reg, prod_im_reg;
    logic signed [WEIGHT_WIDTH-1:0] wr_s, wi_s;
    logic signed [4:0] sr_s, si_s;
    assign wr_s = wrd_reg[2*WEIGHT_WIDTH-1:WEIGHT_WIDTH];
    assign wi_s = wrd_reg[WEIGHT_WIDTH-1:0];
    assign sr_s = $signed({1'b0, sre_reg}) - 5'sd8;
    assign si_s = $signed({1'b0, sim_reg}) - 5'sd8;
    assign rd_en = (state_reg == ST_RD) && (cnt_reg < (CW+1)'(nb));
    assign raddr = {BW'(cnt_reg), cur_pol_reg, pos_reg[EW-1:0]};

    always_ff @(posedge clk)
    begin
        prod_re_reg <= 32'(sr_s) * 32'(wr_s) + 32'(si_s) * 32'(wi_s);
        prod_im_reg <= 32'(si_s) * 32'(wr_s) - 32'(sr_s) * 32'(wi_s);
        rd_b_reg <= CW'(cnt_reg);
        mul_b_reg <= rd_b_reg;
    end

    // cell row
    cell_ctl_t ctl;
    logic [63:0] chain [0:MAX_BEAMS];
    logic out_full_reg;
    logic out_take;
    logic cfg_fire;
    logic cfg_wr;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
    assign cfg_wr = cfg_fire && (cfg_ch.payload.cfg_index == 2'(REG_BEAM_COUNT)
        || cfg_ch.payload.cfg_index == 2'(REG_POL_COUNT));
    assign out_take = !out_full_reg || out_ch.ready;
    assign ctl.mac = mul_v_reg;
    assign ctl.pol = cur_pol_reg;
    assign ctl.clr = cfg_wr;
    assign ctl.shift = (state_reg == ST_OUT) && out_take && !cfg_fire;
    assign chain[MAX_BEAMS] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BEAMS; g++)
        begin : g_cell
            cwb_cell u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl),
                .sel(mul_b_reg == CW'(g)),
                .prod_re(prod_re_reg), .prod_im(prod_im_reg),
                .nbr_in(chain[g+1]), .acc_out(chain[g])
            );
        end
    endgenerate

    // emission counters
    logic [CW-1:0] ob_reg, ob_next;
    logic op_reg, op_next;
    result_t res_reg;
    logic emit_last;
    logic emit;
    assign emit_last = (ob_reg + CW'(1) == nb) && ((op_reg ? 2'd2 : 2'd1) == np);
    // with one polarisation only the first slot of each cell is a result
    assign emit = ctl.shift && (np == 2'd2 || !op_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        ob_next = ob_reg;
        op_next = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready && it.func == FUNC_SAMPLE)
                begin
                    state_next = ST_RD;
                    cnt_next = '0;
                end
            end
            ST_RD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (CW+1)'(nb) + 1'b1)
                begin
                    if (last_pos_reg)
                    begin
                        state_next = ST_OUT;
                        ob_next = '0;
                        op_next = 1'b0;
                        pos_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (ctl.shift)
                begin
                    // unused pol slot of each cell shifts out without a result
                    if (np == 2'd1 && !op_reg)
                        op_next = 1'b1;
                    else if (op_reg || np == 2'd2)
                    begin
                        if (op_reg)
                        begin
                            op_next = 1'b0;
                            ob_next = ob_reg + 1'b1;
                        end
                        else
                            op_next = 1'b1;
                    end
                    if (op_reg && ob_reg + CW'(1) == nb)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr)
        begin
            state_next = ST_IDLE;
            pos_next = '0;
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !cfg_ch.valid;
    assign cfg_ch.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            pos_reg <= '0;
            ob_reg <= '0;
            op_reg <= 1'b0;
            beam_count_reg <= BEAM_COUNT_RESET;
            pol_count_reg <= POL_COUNT_RESET;
            rd_v_reg <= 1'b0;
            mul_v_reg <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            ob_reg <= ob_next;
            op_reg <= op_next;
            rd_v_reg <= rd_en;
            mul_v_reg <= rd_v_reg;
            if (cfg_fire && cfg_ch.payload.cfg_index == 2'(REG_BEAM_COUNT))
                beam_count_reg <= cfg_ch.payload.cfg_data;
            if (cfg_fire && cfg_ch.payload.cfg_index == 2'(REG_POL_COUNT))
                pol_count_reg <= cfg_ch.payload.cfg_data[1:0];
            if (emit)
                out_full_reg <= 1'b1;
            else if (out_ch.ready)
                out_full_reg <= 1'b0;
        end
    end

    // sample capture and result register
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && it.func == FUNC_SAMPLE)
        begin
            sre_reg <= it.sample_byte[7:4];
            sim_reg <= it.sample_byte[3:0];
            if (np == 2'd2)
            begin
                cur_pol_reg <= pos_reg[EW];
                last_pos_reg <= pos_reg >= (EW+1)'(2*ELEMENTS_PER_POL-1);
            end
            else
            begin
                cur_pol_reg <= 1'b0;
                last_pos_reg <= pos_reg >= (EW+1)'(ELEMENTS_PER_POL-1);
            end
        end
        if (emit)
        begin
            res_reg.beam_index <= 4'(ob_reg);
            res_reg.pol_index <= op_reg;
            res_reg.sum_real <= chain[0][63:32];
            res_reg.sum_imag <= chain[0][31:0];
            res_reg.last_of_sample <= emit_last;
        end
    end

    assign out_ch.valid = out_full_reg;
    assign out_ch.payload = res_reg;

    `include "assert_macros.svh"
    `CWB_ASSERT_IMPL(a_no_in_while_busy, clk, rst_n, !in_ch.ready || state_reg == ST_IDLE, "busy")
    `CWB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "drop")
    `CWB_ASSERT_IMPL(a_mac_pipe, clk, rst_n, !(mul_v_reg && state_reg == ST_OUT), "mac in out")
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import cwb_pkg::*;

    localparam int NBEAMS = 16;
    localparam int NELEM = 1024;

    logic clk;
    logic rst_n;

    cwb_item_if   in_ch ();
    cwb_result_if out_ch ();
    cwb_cfg_if    cfg_ch ();

    complex_weighted_beamformer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] w_re [NBEAMS*2*NELEM];
    logic signed [15:0] w_im [NBEAMS*2*NELEM];
    bit w_loaded [NBEAMS*2*NELEM];
    logic signed [31:0] beam_re [NBEAMS*2];
    logic signed [31:0] beam_im [NBEAMS*2];
    int unsigned elem_pos;
    int unsigned cur_beams;
    int unsigned cur_pols;
    result_t expected_sums [$];

    int errors;
    int results_seen;
    int samples_sent;
    bit quiet;

    function automatic int unsigned sat_beams(input logic [4:0] v);
        if (v < 1)
            return 1;
        if (v > NBEAMS)
            return NBEAMS;
        return 32'(v);
    endfunction

    function automatic int unsigned sat_pols(input logic [1:0] v);
        if (v < 1)
            return 1;
        if (v > 2)
            return 2;
        return 32'(v);
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < NBEAMS*2; i++)
        begin
            beam_re[i] = '0;
            beam_im[i] = '0;
        end
        elem_pos = 0;
    endfunction

    // model one accepted transaction
    function automatic void predict_item(input item_t it);
        int unsigned total;
        int unsigned pos;
        int unsigned pol;
        int unsigned el;
        int unsigned a;
        logic signed [31:0] sr;
        logic signed [31:0] si;
        logic signed [31:0] wr;
        logic signed [31:0] wi;
        result_t r;
        total = cur_pols * NELEM;
        if (it.func == FUNC_WEIGHT)
        begin
            a = (it.weight_beam * 2 + it.weight_pol) * NELEM + it.weight_element;
            w_re[a] = it.weight_real;
            w_im[a] = it.weight_imag;
            w_loaded[a] = 1'b1;
            return;
        end
        sr = $signed({28'd0, it.sample_byte[7:4]}) - NIB_OFFSET;
        si = $signed({28'd0, it.sample_byte[3:0]}) - NIB_OFFSET;
        pos = (elem_pos >= total) ? total - 1 : elem_pos;
        pol = pos / NELEM;
        el = pos % NELEM;
        for (int b = 0; b < cur_beams; b++)
        begin
            a = (b * 2 + pol) * NELEM + el;
            wr = w_re[a];
            wi = w_im[a];
            beam_re[b*2+pol] += sr * wr + si * wi;
            beam_im[b*2+pol] += si * wr - sr * wi;
        end
        if (pos + 1 < total)
        begin
            elem_pos = pos + 1;
            return;
        end
        for (int b = 0; b < cur_beams; b++)
            for (int p = 0; p < cur_pols; p++)
            begin
                r.beam_index = 4'(b);
                r.pol_index = 1'(p);
                r.sum_real = beam_re[b*2+p];
                r.sum_imag = beam_im[b*2+p];
                r.last_of_sample = (b + 1 == cur_beams) && (p + 1 == cur_pols);
                expected_sums.push_back(r);
            end
        clear_sums();
    endfunction

    // random stall bursts
    function automatic int stall_len();
        if (quiet || $urandom_range(3, 0) != 0)
            return 0;
        return $urandom_range(16, 1);
    endfunction

    // output sink and checker
    int out_stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_t got;
                result_t exp_r;
                got = out_ch.payload;
                results_seen++;
                if (expected_sums.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result %p", $time, got);
                end
                else
                begin
                    exp_r = expected_sums.pop_front();
                    if (got.beam_index !== exp_r.beam_index) begin errors++;
                        $display("%0t beam_index exp %0d got %0d", $time,
                                 exp_r.beam_index, got.beam_index); end
                    if (got.pol_index !== exp_r.pol_index) begin errors++;
                        $display("%0t pol_index exp %0d got %0d", $time,
                                 exp_r.pol_index, got.pol_index); end
                    if (got.sum_real !== exp_r.sum_real) begin errors++;
                        $display("%0t sum_real exp %0d got %0d", $time,
                                 exp_r.sum_real, got.sum_real); end
                    if (got.sum_imag !== exp_r.sum_imag) begin errors++;
                        $display("%0t sum_imag exp %0d got %0d", $time,
                                 exp_r.sum_imag, got.sum_imag); end
                    if (got.last_of_sample !== exp_r.last_of_sample) begin errors++;
                        $display("%0t last_of_sample exp %0d got %0d", $time,
                                 exp_r.last_of_sample, got.last_of_sample); end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_stall = stall_len();
                out_ch.ready <= (out_stall == 0);
            end
        end
    end

    // send one transaction with optional idle gap; valid stays up for the next one
    task automatic send_item(input item_t it);
        int gap;
        gap = stall_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_item(it);
        if (it.func == FUNC_SAMPLE)
            samples_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{cfg_index: idx, cfg_data: val};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == 2'(REG_BEAM_COUNT))
            cur_beams = sat_beams(val);
        else if (idx == 2'(REG_POL_COUNT))
            cur_pols = sat_pols(val[1:0]);
        if (idx == 2'(REG_BEAM_COUNT) || idx == 2'(REG_POL_COUNT))
            clear_sums();
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic item_t rand_weight(input int unsigned b, input int unsigned p,
                                          input int unsigned e);
        item_t it;
        it = item_t'(56'({$urandom, $urandom}));
        it.func = FUNC_WEIGHT;
        it.weight_beam = 4'(b);
        it.weight_pol = 1'(p);
        it.weight_element = 10'(e);
        return it;
    endfunction

    function automatic item_t rand_sample();
        item_t it;
        it = item_t'(56'({$urandom, $urandom}));
        it.func = FUNC_SAMPLE;
        return it;
    endfunction

    // fill every weight entry the phase may read that is still unwritten
    task automatic load_weights(input int unsigned nb, input int unsigned np);
        for (int b = 0; b < nb; b++)
            for (int p = 0; p < np; p++)
                for (int e = 0; e < NELEM; e++)
                    if (!w_loaded[(b * 2 + p) * NELEM + e])
                        send_item(rand_weight(b, p, e));
    endtask

    // one full time sample of random bytes
    task automatic send_time_sample();
        for (int i = 0; i < cur_pols * NELEM; i++)
            send_item(rand_sample());
    endtask

    typedef struct {
        item_t it;
        bit    has_exp;
        result_t exp_r;
    } stim_row_t;

    stim_row_t dir_rows [$];

    initial
    begin
        stim_row_t row;
        item_t it;
        errors = 0;
        results_seen = 0;
        samples_sent = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        cur_beams = BEAM_COUNT_RESET;
        cur_pols = POL_COUNT_RESET;
        for (int i = 0; i < NBEAMS*2*NELEM; i++)
        begin
            w_re[i] = '0;
            w_im[i] = '0;
            w_loaded[i] = 1'b0;
        end
        clear_sums();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed: one beam, one pol, extreme weights at every element
        write_reg(2'(REG_BEAM_COUNT), 5'd0);
        write_reg(2'(REG_POL_COUNT), 5'd0);
        it = '0;
        it.func = FUNC_WEIGHT;
        it.weight_real = 16'sh7fff;
        it.weight_imag = -16'sh8000;
        for (int e = 0; e < NELEM; e++)
        begin
            it.weight_element = 10'(e);
            send_item(it);
        end
        // ignored-field weight to another beam, later used at 16 beams
        it.weight_beam = 4'd15;
        it.weight_pol = 1'b1;
        it.weight_element = 10'd1023;
        it.sample_byte = 8'hff;
        send_item(it);
        // samples of all-zero parts except extremes at two elements
        for (int e = 0; e < NELEM; e++)
        begin
            row.it = '0;
            row.it.func = FUNC_SAMPLE;
            row.it.sample_byte = 8'h88;
            row.has_exp = 1'b0;
            if (e == 0)
                row.it.sample_byte = 8'h00;
            if (e == NELEM - 1)
            begin
                row.it.sample_byte = 8'hff;
                row.it.weight_real = 16'sh1234;
                row.has_exp = 1'b1;
                // (-8,-8)*conj(w) + (7,7)*conj(w), w = 32767 - j32768
                row.exp_r = '{beam_index: 4'd0, pol_index: 1'b0,
                              sum_real: 32'sd1, sum_imag: -32'sd65535,
                              last_of_sample: 1'b1};
            end
            dir_rows.push_back(row);
        end
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].it);
            if (dir_rows[i].has_exp && expected_sums.size() != 0 &&
                expected_sums[$] != dir_rows[i].exp_r)
            begin
                errors++;
                $display("%0t directed row %0d exp %p got %p", $time, i,
                         dir_rows[i].exp_r, expected_sums[$]);
            end
        end
        drain_results();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            int unsigned nb;
            int unsigned np;
            case (ph)
                0: begin nb = 1; np = 2; end
                1: begin nb = 16; np = 1; end
                2: begin nb = 16; np = 2; end
                3: begin nb = $urandom_range(15, 2); np = 2; end
                default: begin nb = $urandom_range(16, 1); np = $urandom_range(2, 1); end
            endcase
            write_reg(2'(REG_BEAM_COUNT), (ph == 2) ? 5'd31 : nb[4:0]);
            write_reg(2'(REG_POL_COUNT), (ph == 2) ? 5'd3 : np[4:0]);
            if (ph == 4)
                quiet = 1'b1;
            load_weights(cur_beams, cur_pols);
            // out-of-store-range elements cannot occur at these widths; noise rewrites
            for (int k = 0; k < 96; k++)
                send_item(rand_weight($urandom_range(15, 0), $urandom_range(1, 0),
                                      $urandom_range(1023, 0)));
            send_time_sample();
            send_time_sample();
            drain_results();
        end

        $display("covered %0d sample transactions, %0d results checked",
                 samples_sent, results_seen);
        $display("register settings swept from 1 to 16 beams with one and two pols");
        if (errors == 0 && expected_sums.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== complex_weighted_beamformer_core.f =====
+incdir+rtl
rtl/cwb_pkg.sv
rtl/cwb_if.sv
rtl/cwb_cell.sv
rtl/complex_weighted_beamformer_core.sv
sim/tb_top.sv
